### sv/bcd_pkg.sv
// ---------------------------------------------------------------------------
// bcd_pkg
// Shared types, format codes and fixed-point helpers for the block decoder.
// ---------------------------------------------------------------------------
package bcd_pkg;

  // block format codes; any code with bit 1 set decodes interpolated alpha
  localparam logic [1:0] FMT_BC1 = 2'd0;
  localparam logic [1:0] FMT_BC2 = 2'd1;
  localparam logic [1:0] FMT_BC3 = 2'd2;

  // decoded block handed to the row unit
  typedef struct packed {
    logic [3:0][31:0] pal;   // palette entries, RGBA packed
    logic [7:0][7:0]  alut;  // interpolated alpha table
    logic [31:0]      idx;   // 2-bit colour indices
    logic [63:0]      ab;    // alpha half of the block
    logic [1:0]       fmt;   // block format
  } bcd_block_t;

  // 5-bit endpoint to 8 bits, v*255/31 truncated, via reciprocal multiply
  function automatic logic [7:0] exp5(input logic [4:0] v);
    logic [25:0] prod;
    prod = 26'(v) * 26'd2156535;
    return prod[25:18];
  endfunction

  // 6-bit endpoint to 8 bits, v*255/63 truncated
  function automatic logic [7:0] exp6(input logic [5:0] v);
    logic [27:0] prod;
    prod = 28'(v) * 28'd4244475;
    return prod[27:20];
  endfunction

  // x/3 for x up to 255*3+1
  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'd683;
    return prod[18:11];
  endfunction

  // x/7 for x up to 255*7
  function automatic logic [7:0] div7(input logic [10:0] x);
    logic [21:0] prod;
    prod = 22'(x) * 22'd2341;
    return prod[21:14];
  endfunction

  // x/5 for x up to 255*5
  function automatic logic [7:0] div5(input logic [10:0] x);
    logic [21:0] prod;
    prod = 22'(x) * 22'd3277;
    return prod[21:14];
  endfunction

endpackage

### sv/bcd_row_unit.sv
// ---------------------------------------------------------------------------
// bcd_row_unit
// Holds one decoded block and sends it out as four registered row beats.
// ---------------------------------------------------------------------------
module bcd_row_unit import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  bcd_block_t  in_blk,
  output logic        take,
  output logic        row_valid,
  output logic [1:0]  row_index,
  output logic [31:0] pixel_col0,
  output logic [31:0] pixel_col1,
  output logic [31:0] pixel_col2,
  output logic [31:0] pixel_col3,
  output logic        last_row
);

  logic             held;
  logic [1:0]       row;
  bcd_block_t       blk;
  logic [3:0][31:0] pix;
  logic [3:0][1:0]  sel;
  logic [3:0][3:0]  nib;
  logic [3:0][2:0]  code;
  logic [3:0][3:0]  pos;

  // free when empty or when the last row is going out this cycle
  assign take = !held || (row == 2'd3);

  // block holding register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      row  <= 2'd0;
    end else if (take) begin
      held <= in_valid;
      row  <= 2'd0;
    end else begin
      row  <= row + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      blk <= in_blk;
    end
  end

  // per-column palette and alpha selection for the current row
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      pos[c]  = {row, 2'(c)};
      sel[c]  = blk.idx[{pos[c], 1'b0} +: 2];
      nib[c]  = blk.ab[{pos[c], 2'b00} +: 4];
      code[c] = blk.ab[6'(6'd16 + 6'(pos[c]) * 6'd3) +: 3];
      if (blk.fmt == FMT_BC2) begin
        pix[c] = {nib[c], nib[c], blk.pal[sel[c]][23:0]};
      end else if (blk.fmt >= FMT_BC3) begin
        pix[c] = {blk.alut[code[c]], blk.pal[sel[c]][23:0]};
      end else begin
        pix[c] = blk.pal[sel[c]];
      end
    end
  end

  // output beat registers
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= 1'b0;
    end else begin
      row_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    row_index  <= row;
    last_row   <= (row == 2'd3);
    pixel_col0 <= pix[0];
    pixel_col1 <= pix[1];
    pixel_col2 <= pix[2];
    pixel_col3 <= pix[3];
  end

endmodule

### sv/bc_block_texture_decoder.sv
// ---------------------------------------------------------------------------
// bc_block_texture_decoder
// BC1/BC2/BC3 4x4 block decoder giving four rows of RGBA8 pixels per block.
// ---------------------------------------------------------------------------
// Usage:
//   Input: drive alpha_block, color_block and start; the block is taken at a
//   rising edge with start high and busy low. alpha_block is ignored in BC1.
//   Config: cfg_we with cfg_data writes block_format (0 BC1, 1 BC2, 2 BC3);
//   write it only while no block is in flight.
//   Output: each row beat shows on row_valid for one cycle with row_index,
//   four pixels and last_row; rows come top first in consecutive cycles.
//   Path: a block passes the input register, endpoint/alpha-sum stage,
//   palette stage, row holder and output register before its first row
//   beat appears.
//   Flow: the row unit emits one row per cycle; a new block is taken in the
//   same cycle as the last row of the previous one leaves, and busy rises
//   when the stages fill up.
//   Reset: empties the pipeline, clears row_valid and sets the format to BC1.
//   The receiver cannot stall; every beat must be taken when shown.
// ---------------------------------------------------------------------------
module bc_block_texture_decoder import bcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] alpha_block,
  input  logic [63:0] color_block,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_data,
  output logic        row_valid,
  output logic [1:0]  row_index,
  output logic [31:0] pixel_col0,
  output logic [31:0] pixel_col1,
  output logic [31:0] pixel_col2,
  output logic [31:0] pixel_col3,
  output logic        last_row
);

  logic [1:0] block_format;

  // stage 1: captured block
  logic        v1;
  logic [63:0] ab1;
  logic [63:0] cb1;
  logic [1:0]  fmt1;

  // stage 2: expanded endpoints and alpha sums
  logic                 v2;
  logic [2:0][7:0]      e0c2;
  logic [2:0][7:0]      e1c2;
  logic                 four2;
  logic                 gt2;
  logic [7:0]           a0_2;
  logic [7:0]           a1_2;
  logic [5:0][10:0]     num2;
  logic [31:0]          idx2;
  logic [63:0]          ab2;
  logic [1:0]           fmt2;

  // stage 3: decoded block
  logic       v3;
  bcd_block_t blk3;

  logic en1;
  logic en2;
  logic en3;
  logic take;

  // stage 2 inputs
  logic [15:0]      c0;
  logic [15:0]      c1;
  logic [7:0]       a0;
  logic [7:0]       a1;
  logic             gt;
  logic [5:0][10:0] num;

  // stage 3 inputs
  logic [2:0][7:0]  t0;
  logic [2:0][7:0]  t1;
  logic [2:0][7:0]  mid;
  logic [8:0]       msum;
  bcd_block_t       blk_next;

  // format register
  always_ff @(posedge clk) begin
    if (rst) begin
      block_format <= FMT_BC1;
    end else if (cfg_we) begin
      block_format <= cfg_data;
    end
  end

  // stage enables: a stage loads when empty or when its contents move on
  assign en3  = !v3 || take;
  assign en2  = !v2 || en3;
  assign en1  = !v1 || en2;
  assign busy = !en1;

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ab1  <= alpha_block;
      cb1  <= color_block;
      fmt1 <= block_format;
    end
  end

  // endpoint expansion and alpha weighted sums
  always_comb begin
    c0 = cb1[15:0];
    c1 = cb1[31:16];
    a0 = ab1[7:0];
    a1 = ab1[15:8];
    gt = a0 > a1;
    for (int i = 0; i < 6; i++) begin
      if (gt) begin
        num[i] = 11'(a0) * 11'(6 - i) + 11'(a1) * 11'(i + 1);
      end else if (i < 4) begin
        num[i] = 11'(a0) * 11'(4 - i) + 11'(a1) * 11'(i + 1);
      end else begin
        num[i] = 11'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      e0c2  <= {exp5(c0[4:0]), exp6(c0[10:5]), exp5(c0[15:11])};
      e1c2  <= {exp5(c1[4:0]), exp6(c1[10:5]), exp5(c1[15:11])};
      four2 <= (fmt1 != FMT_BC1) || (c0 > c1);
      gt2   <= gt;
      a0_2  <= a0;
      a1_2  <= a1;
      num2  <= num;
      idx2  <= cb1[63:32];
      ab2   <= ab1;
      fmt2  <= fmt1;
    end
  end

  // palette and alpha table
  always_comb begin
    msum = 9'd0;
    for (int ch = 0; ch < 3; ch++) begin
      t0[ch]  = div3(10'({e0c2[ch], 1'b0}) + 10'(e1c2[ch]) + 10'd1);
      t1[ch]  = div3(10'(e0c2[ch]) + 10'({e1c2[ch], 1'b0}) + 10'd1);
      msum    = 9'(e0c2[ch]) + 9'(e1c2[ch]);
      mid[ch] = msum[8:1];
    end
    blk_next.pal[0] = {8'hFF, e0c2};
    blk_next.pal[1] = {8'hFF, e1c2};
    if (four2) begin
      blk_next.pal[2] = {8'hFF, t0};
      blk_next.pal[3] = {8'hFF, t1};
    end else begin
      blk_next.pal[2] = {8'hFF, mid};
      blk_next.pal[3] = 32'd0;
    end
    blk_next.alut[0] = a0_2;
    blk_next.alut[1] = a1_2;
    for (int i = 0; i < 6; i++) begin
      if (gt2) begin
        blk_next.alut[i + 2] = div7(num2[i]);
      end else if (i < 4) begin
        blk_next.alut[i + 2] = div5(num2[i]);
      end else if (i == 4) begin
        blk_next.alut[i + 2] = 8'd0;
      end else begin
        blk_next.alut[i + 2] = 8'hFF;
      end
    end
    blk_next.idx = idx2;
    blk_next.ab  = ab2;
    blk_next.fmt = fmt2;
  end

  // stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      blk3 <= blk_next;
    end
  end

  // row output unit
  bcd_row_unit u_rows (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (v3),
    .in_blk     (blk3),
    .take       (take),
    .row_valid  (row_valid),
    .row_index  (row_index),
    .pixel_col0 (pixel_col0),
    .pixel_col1 (pixel_col1),
    .pixel_col2 (pixel_col2),
    .pixel_col3 (pixel_col3),
    .last_row   (last_row)
  );

  // rows of one block come out in consecutive cycles, counting up
  a_rows_contiguous: assert property (@(posedge clk) disable iff (rst)
    row_valid && !last_row |=> row_valid && (row_index == $past(row_index) + 2'd1))
    else $error("row beats of one block not contiguous");

  // last_row marks exactly the fourth row
  a_last_row: assert property (@(posedge clk) disable iff (rst)
    row_valid |-> (last_row == (row_index == 2'd3)))
    else $error("last_row does not match row_index");

  // an accepted block lands in stage 1
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> v1)
    else $error("accepted block lost at stage 1");

  // busy only when every stage is full
  a_busy_full: assert property (@(posedge clk) disable iff (rst)
    busy |-> v1 && v2 && v3)
    else $error("busy with an empty stage");

endmodule
